/* hdl/bpc_pkg.sv */
package bpc_pkg;

  localparam int unsigned TDIV_W = 27;
  localparam int unsigned PDIV_W = 32;

  localparam logic [2:0] REG_AC1 = 3'd0;
  localparam logic [2:0] REG_AC2 = 3'd1;
  localparam logic [2:0] REG_AC3 = 3'd2;
  localparam logic [2:0] REG_AC4 = 3'd3;
  localparam logic [2:0] REG_AC56 = 3'd4;
  localparam logic [2:0] REG_B1 = 3'd5;
  localparam logic [2:0] REG_B2 = 3'd6;
  localparam logic [2:0] REG_MCMD = 3'd7;

  localparam logic [31:0] T_OFFSET = 32'd4000;
  localparam logic [31:0] P_LIN_C = 32'd3038;
  localparam logic [31:0] P_NEG_C = 32'hFFFF_E343; // -7357
  localparam logic [31:0] P_ADD_C = 32'd3791;
  localparam logic [31:0] P_SCALE = 32'd50000;
  localparam logic [31:0] B4_BIAS = 32'd32768;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TDIV0 = 2'd1,
    ST_PDIV0 = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        tz;
    logic [15:0] temp;
    logic [31:0] b6;
    logic [15:0] up;
  } tmp_t;

  typedef struct packed {
    logic        valid;
    logic        tz;
    logic [15:0] temp;
    logic [31:0] b4;
    logic [31:0] b7;
  } coef_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] den,
                                           input logic nbit);
    logic [32:0] trial;
    logic [32:0] diff;
    trial = {rem, nbit};
    diff = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      div_step = {1'b1, diff[31:0]};
    end else begin
      div_step = {1'b0, trial[31:0]};
    end
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

/* hdl/bpc_temp.sv */
module bpc_temp
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  input  logic [15:0] ut_i,
  input  logic [15:0] up_i,
  output tmp_t        tmp_o
);

  logic        v0_q;
  logic [15:0] ut_q, up0_q;
  logic        v1_q;
  logic [31:0] x1_q;
  logic [15:0] up1_q;

  logic signed [16:0] dut;
  logic [31:0] m1;
  logic [31:0] div;
  logic [15:0] mc_abs;

  logic              dv_q   [TDIV_W+1];
  logic [31:0]       rem_q  [TDIV_W+1];
  logic [TDIV_W-1:0] num_q  [TDIV_W+1];
  logic [TDIV_W-1:0] quo_q  [TDIV_W+1];
  logic [31:0]       den_q  [TDIV_W+1];
  logic [31:0]       dx1_q  [TDIV_W+1];
  logic              neg_q  [TDIV_W+1];
  logic              dz_q   [TDIV_W+1];
  logic [15:0]       dup_q  [TDIV_W+1];
  logic [32:0]       step   [TDIV_W];

  logic [31:0] q32, x2, b5, b5r, t32;
  logic [15:0] temp_d;
  logic        tv_q;
  logic        tz_q;
  logic [15:0] temp_q;
  logic [31:0] b6_q;
  logic [15:0] tup_q;

  assign dut = $signed({1'b0, ut_q}) - $signed({1'b0, cfg_i.ac6});
  assign m1 = {{15{dut[16]}}, dut} * {16'd0, cfg_i.ac5};
  assign div = x1_q + sx16(cfg_i.md);
  assign mc_abs = cfg_i.mc[15] ? (16'd0 - cfg_i.mc) : cfg_i.mc;

  always_comb begin
    for (int k = 0; k < TDIV_W; k++) begin
      step[k] = div_step(rem_q[k], den_q[k], num_q[k][TDIV_W-1-k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      for (int k = 0; k <= TDIV_W; k++) dv_q[k] <= 1'b0;
      tv_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      dv_q[0] <= v1_q;
      for (int k = 0; k < TDIV_W; k++) dv_q[k+1] <= dv_q[k];
      tv_q <= dv_q[TDIV_W];
    end
  end

  always_ff @(posedge clk_i) begin
    ut_q  <= ut_i;
    up0_q <= up_i;
    x1_q  <= 32'($signed(m1) >>> 15);
    up1_q <= up0_q;
    // divider load
    rem_q[0] <= '0;
    num_q[0] <= {mc_abs, 11'd0};
    quo_q[0] <= '0;
    den_q[0] <= div[31] ? (32'd0 - div) : div;
    dx1_q[0] <= x1_q;
    neg_q[0] <= cfg_i.mc[15] ^ div[31];
    dz_q[0]  <= (div == 32'd0);
    dup_q[0] <= up1_q;
    for (int k = 0; k < TDIV_W; k++) begin
      rem_q[k+1] <= step[k][31:0];
      num_q[k+1] <= num_q[k];
      quo_q[k+1] <= {quo_q[k][TDIV_W-2:0], step[k][32]};
      den_q[k+1] <= den_q[k];
      dx1_q[k+1] <= dx1_q[k];
      neg_q[k+1] <= neg_q[k];
      dz_q[k+1]  <= dz_q[k];
      dup_q[k+1] <= dup_q[k];
    end
    tz_q   <= dz_q[TDIV_W];
    temp_q <= dz_q[TDIV_W] ? 16'd0 : temp_d;
    b6_q   <= b5 - T_OFFSET;
    tup_q  <= dup_q[TDIV_W];
  end

  always_comb begin
    q32 = {{(32-TDIV_W){1'b0}}, quo_q[TDIV_W]};
    x2 = neg_q[TDIV_W] ? (32'd0 - q32) : q32;
    b5 = dx1_q[TDIV_W] + x2;
    b5r = b5 + 32'd8;
    t32 = 32'($signed(b5r) >>> 4);
    if ($signed(t32) > 32'sd32767) begin
      temp_d = 16'h7FFF;
    end else if ($signed(t32) < -32'sd32768) begin
      temp_d = 16'h8000;
    end else begin
      temp_d = t32[15:0];
    end
  end

  assign tmp_o = '{valid: tv_q, tz: tz_q, temp: temp_q, b6: b6_q, up: tup_q};

endmodule

/* hdl/bpc_poly.sv */
module bpc_poly
  import bpc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  tmp_t  tmp_i,
  output coef_t coef_o
);

  // stage a: products of b6
  logic        va_q, tza_q;
  logic [15:0] tempa_q, upa_q;
  logic [31:0] psq_q, p2a_q, p3a_q;
  // stage b: sq
  logic        vb_q, tzb_q;
  logic [15:0] tempb_q, upb_q;
  logic [31:0] sq_q, p2b_q, p3b_q;
  // stage c: products of sq
  logic        vc_q, tzc_q;
  logic [15:0] tempc_q, upc_q;
  logic [31:0] mb1_q, mb2_q, p2c_q, p3c_q;
  // stage d: b3 and b4 factor
  logic        vd_q, tzd_q;
  logic [15:0] tempd_q, upd_q;
  logic [31:0] b3_q, u_q;
  logic        cv_q, ctz_q;
  logic [15:0] ctemp_q;
  logic [31:0] cb4_q, cb7_q;

  logic [31:0] x3, b3s, x3p, x3ps, b4m;

  always_comb begin
    x3   = 32'($signed(mb2_q) >>> 11) + 32'($signed(p2c_q) >>> 11);
    b3s  = (sx16(cfg_i.ac1) << 2) + x3 + 32'd2;
    x3p  = 32'($signed(p3c_q) >>> 13) + 32'($signed(mb1_q) >>> 16) + 32'd2;
    x3ps = 32'($signed(x3p) >>> 2);
    b4m  = {16'd0, cfg_i.ac4} * u_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      cv_q <= 1'b0;
    end else begin
      va_q <= tmp_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      cv_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tza_q   <= tmp_i.tz;
    tempa_q <= tmp_i.temp;
    upa_q   <= tmp_i.up;
    psq_q   <= tmp_i.b6 * tmp_i.b6;
    p2a_q   <= sx16(cfg_i.ac2) * tmp_i.b6;
    p3a_q   <= sx16(cfg_i.ac3) * tmp_i.b6;

    tzb_q   <= tza_q;
    tempb_q <= tempa_q;
    upb_q   <= upa_q;
    sq_q    <= 32'($signed(psq_q) >>> 12);
    p2b_q   <= p2a_q;
    p3b_q   <= p3a_q;

    tzc_q   <= tzb_q;
    tempc_q <= tempb_q;
    upc_q   <= upb_q;
    mb2_q   <= sx16(cfg_i.b2) * sq_q;
    mb1_q   <= sx16(cfg_i.b1) * sq_q;
    p2c_q   <= p2b_q;
    p3c_q   <= p3b_q;

    tzd_q   <= tzc_q;
    tempd_q <= tempc_q;
    upd_q   <= upc_q;
    b3_q    <= 32'($signed(b3s) >>> 2);
    u_q     <= x3ps + B4_BIAS;

    ctz_q   <= tzd_q;
    ctemp_q <= tempd_q;
    cb4_q   <= b4m >> 15;
    cb7_q   <= ({16'd0, upd_q} - b3_q) * P_SCALE;
  end

  assign coef_o = '{valid: cv_q, tz: ctz_q, temp: ctemp_q, b4: cb4_q, b7: cb7_q};

endmodule

/* hdl/bpc_press.sv */
module bpc_press
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  coef_t       coef_i,
  output logic        done_o,
  output logic [15:0] temp_o,
  output logic [18:0] pres_o,
  output status_e     status_o
);

  logic              dv_q  [PDIV_W+1];
  logic [31:0]       rem_q [PDIV_W+1];
  logic [PDIV_W-1:0] num_q [PDIV_W+1];
  logic [PDIV_W-1:0] quo_q [PDIV_W+1];
  logic [31:0]       den_q [PDIV_W+1];
  logic              top_q [PDIV_W+1];
  logic              tz_q  [PDIV_W+1];
  logic              bz_q  [PDIV_W+1];
  logic [15:0]       tmp_q [PDIV_W+1];
  logic [32:0]       step  [PDIV_W];

  // correction stages
  logic        vg_q, tzg_q, bzg_q;
  logic [15:0] tempg_q;
  logic [31:0] pg_q, ttg_q, m7g_q;
  logic        vh_q, tzh_q, bzh_q;
  logic [15:0] temph_q;
  logic [31:0] ph_q, x1h_q, x2h_q;

  logic        done_q;
  logic [15:0] temp_q;
  logic [18:0] pres_q;
  status_e     status_q;

  logic [31:0] pq, t8, x1m, sumc, p2;
  logic [18:0] pres_d;

  always_comb begin
    for (int k = 0; k < PDIV_W; k++) begin
      step[k] = div_step(rem_q[k], den_q[k], num_q[k][PDIV_W-1-k]);
    end
  end

  always_comb begin
    // b7 with its top bit set divides first and doubles after
    pq   = top_q[PDIV_W] ? {quo_q[PDIV_W][30:0], 1'b0} : quo_q[PDIV_W];
    t8   = 32'($signed(pq) >>> 8);
    x1m  = ttg_q * P_LIN_C;
    sumc = x1h_q + x2h_q + P_ADD_C;
    p2   = ph_q + 32'($signed(sumc) >>> 4);
    if ($signed(p2) > 32'sd262143) begin
      pres_d = 19'h3FFFF;
    end else if ($signed(p2) < -32'sd262144) begin
      pres_d = 19'h40000;
    end else begin
      pres_d = p2[18:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= PDIV_W; k++) dv_q[k] <= 1'b0;
      vg_q   <= 1'b0;
      vh_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      dv_q[0] <= coef_i.valid;
      for (int k = 0; k < PDIV_W; k++) dv_q[k+1] <= dv_q[k];
      vg_q   <= dv_q[PDIV_W];
      vh_q   <= vg_q;
      done_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    num_q[0] <= coef_i.b7[31] ? coef_i.b7 : {coef_i.b7[30:0], 1'b0};
    quo_q[0] <= '0;
    den_q[0] <= coef_i.b4;
    top_q[0] <= coef_i.b7[31];
    tz_q[0]  <= coef_i.tz;
    bz_q[0]  <= (coef_i.b4 == 32'd0);
    tmp_q[0] <= coef_i.temp;
    for (int k = 0; k < PDIV_W; k++) begin
      rem_q[k+1] <= step[k][31:0];
      num_q[k+1] <= num_q[k];
      quo_q[k+1] <= {quo_q[k][PDIV_W-2:0], step[k][32]};
      den_q[k+1] <= den_q[k];
      top_q[k+1] <= top_q[k];
      tz_q[k+1]  <= tz_q[k];
      bz_q[k+1]  <= bz_q[k];
      tmp_q[k+1] <= tmp_q[k];
    end

    tzg_q   <= tz_q[PDIV_W];
    bzg_q   <= bz_q[PDIV_W];
    tempg_q <= tmp_q[PDIV_W];
    pg_q    <= pq;
    ttg_q   <= t8 * t8;
    m7g_q   <= P_NEG_C * pq;

    tzh_q   <= tzg_q;
    bzh_q   <= bzg_q;
    temph_q <= tempg_q;
    ph_q    <= pg_q;
    x1h_q   <= 32'($signed(x1m) >>> 16);
    x2h_q   <= 32'($signed(m7g_q) >>> 16);

    temp_q <= temph_q;
    if (tzh_q) begin
      pres_q   <= '0;
      status_q <= ST_TDIV0;
    end else if (bzh_q) begin
      pres_q   <= '0;
      status_q <= ST_PDIV0;
    end else begin
      pres_q   <= pres_d;
      status_q <= ST_OK;
    end
  end

  assign done_o   = done_q;
  assign temp_o   = temp_q;
  assign pres_o   = pres_q;
  assign status_o = status_q;

endmodule

/* hdl/baro_temp_pressure_compensation.sv */
// channel   ports                                          handshake
// -------   ---------------------------------------------  ---------------------------
// input     raw_temperature_i, raw_pressure_i              start_i high, busy_o low
// result    temperature_tenths_o, pressure_pascal_o,       done_o high for one cycle
//           status_o
// config    cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i high
//
// one word enters per cycle; busy_o never rises
// done_o rises after the registers of the temperature, polynomial and pressure stages, mostly the two
// bit-per-stage divider chains (27 and 32 steps)
// async active-low reset clears valid bits and calibration registers
// results cannot be held off; each appears once, in order, for one cycle
module baro_temp_pressure_compensation
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] raw_temperature_i,
  input  logic [15:0] raw_pressure_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic signed [18:0] pressure_pascal_o,
  output logic [1:0]  status_o
);

  cfg_t    cfg_q;
  tmp_t    tmp;
  coef_t   coef;
  logic [15:0] temp_w;
  logic [18:0] pres_w;
  status_e status_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AC1: cfg_q.ac1 <= cfg_data_i[15:0];
        REG_AC2: cfg_q.ac2 <= cfg_data_i[15:0];
        REG_AC3: cfg_q.ac3 <= cfg_data_i[15:0];
        REG_AC4: cfg_q.ac4 <= cfg_data_i[15:0];
        REG_AC56: begin
          cfg_q.ac5 <= cfg_data_i[31:16];
          cfg_q.ac6 <= cfg_data_i[15:0];
        end
        REG_B1: cfg_q.b1 <= cfg_data_i[15:0];
        REG_B2: cfg_q.b2 <= cfg_data_i[15:0];
        REG_MCMD: begin
          cfg_q.mc <= cfg_data_i[31:16];
          cfg_q.md <= cfg_data_i[15:0];
        end
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  bpc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (start_i & ~busy_o),
    .ut_i    (raw_temperature_i),
    .up_i    (raw_pressure_i),
    .tmp_o   (tmp)
  );

  bpc_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .tmp_i  (tmp),
    .coef_o (coef)
  );

  bpc_press u_press (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coef_i   (coef),
    .done_o   (done_o),
    .temp_o   (temp_w),
    .pres_o   (pres_w),
    .status_o (status_w)
  );

  assign temperature_tenths_o = $signed(temp_w);
  assign pressure_pascal_o    = $signed(pres_w);
  assign status_o             = status_w;

endmodule

/* bench/baro_temp_pressure_compensation_tb.sv */
module baro_temp_pressure_compensation_tb;
  import bpc_pkg::*;

  typedef struct {
    logic signed [15:0] temp;
    logic signed [18:0] pres;
    status_e            stat;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] raw_temperature_i = '0;
  logic [15:0] raw_pressure_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        done_o;
  logic signed [15:0] temperature_tenths_o;
  logic signed [18:0] pressure_pascal_o;
  logic [1:0]  status_o;

  baro_temp_pressure_compensation dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  bit [31:0] cal[8];
  reading_t  pending[$];
  int        errors = 0;
  int        words_in = 0;
  int        words_out = 0;
  int        stat_seen[3] = '{0, 0, 0};
  int        quiet = 0;
  bit        calm = 0;
  localparam int WATCHDOG = 5000;

  function automatic longint w32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint sx(bit [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic reading_t compensate(bit [15:0] ut_raw, bit [15:0] up_raw);
    longint mask = 64'hFFFF_FFFF;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    longint x1, x2, x3, dv, b5, b6, sq, b3, b4, b7, q, p;
    reading_t r;
    ac1 = sx(cal[REG_AC1][15:0]);
    ac2 = sx(cal[REG_AC2][15:0]);
    ac3 = sx(cal[REG_AC3][15:0]);
    ac4 = longint'(cal[REG_AC4][15:0]);
    ac5 = longint'(cal[REG_AC56][31:16]);
    ac6 = longint'(cal[REG_AC56][15:0]);
    b1 = sx(cal[REG_B1][15:0]);
    b2 = sx(cal[REG_B2][15:0]);
    mc = sx(cal[REG_MCMD][31:16]);
    md = sx(cal[REG_MCMD][15:0]);
    ut = longint'(ut_raw);
    up = longint'(up_raw);
    r.temp = '0;
    r.pres = '0;
    x1 = w32((ut - ac6) * ac5) >>> 15;
    dv = w32(x1 + md);
    if (dv == 0) begin
      r.stat = ST_TDIV0;
      return r;
    end
    x2 = w32(w32(mc * 2048) / dv);
    b5 = w32(x1 + x2);
    r.temp = 16'(clamp(w32(b5 + 8) >>> 4, -32768, 32767));
    b6 = w32(b5 - 4000);
    sq = w32(b6 * b6) >>> 12;
    x1 = w32(b2 * sq) >>> 11;
    x2 = w32(ac2 * b6) >>> 11;
    x3 = w32(x1 + x2);
    b3 = w32(w32(w32(ac1 * 4) + x3) + 2) >>> 2;
    x1 = w32(ac3 * b6) >>> 13;
    x2 = w32(b1 * sq) >>> 16;
    x3 = w32(w32(x1 + x2) + 2) >>> 2;
    b4 = ((ac4 * (w32(x3 + 32768) & mask)) & mask) >> 15;
    if (b4 == 0) begin
      r.stat = ST_PDIV0;
      return r;
    end
    b7 = (((up - b3) & mask) * 50000) & mask;
    if (b7 < 64'h8000_0000) q = (b7 * 2) / b4;
    else q = ((b7 / b4) * 2) & mask;
    p = w32(q);
    x1 = w32((p >>> 8) * (p >>> 8));
    x1 = w32(x1 * 3038) >>> 16;
    x2 = w32(-7357 * p) >>> 16;
    p = w32(p + (w32(w32(x1 + x2) + 3791) >>> 4));
    r.pres = 19'(clamp(p, -262144, 262143));
    r.stat = ST_OK;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni && done_o) begin
      words_out++;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending.pop_front();
        if (status_o < 3) stat_seen[status_o]++;
        if (temperature_tenths_o !== e.temp) begin
          $error("temperature_tenths expected %0d got %0d", e.temp, temperature_tenths_o);
          errors++;
        end
        if (pressure_pascal_o !== e.pres) begin
          $error("pressure_pascal expected %0d got %0d", e.pres, pressure_pascal_o);
          errors++;
        end
        if (status_o !== e.stat) begin
          $error("status expected %0d got %0d", e.stat, status_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired");
      $display("baro_temp_pressure_compensation regression: fail");
      $finish;
    end
  end

  task automatic send_word(bit [15:0] ut, bit [15:0] up);
    start_i <= 1'b1;
    raw_temperature_i <= ut;
    raw_pressure_i <= up;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending.push_back(compensate(ut, up));
    words_in++;
  endtask

  task automatic pause(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // random sender gaps, none in the calm tail
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 13));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic load_cal(bit [31:0] v[8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= v[i];
      cal[i] = (i == REG_AC56 || i == REG_MCMD) ? v[i] : {16'h0, v[i][15:0]};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    @(posedge clk_i);
  endtask

  function automatic void typical_cal(output bit [31:0] v[8]);
    v[REG_AC1] = 32'(16'sd408);
    v[REG_AC2] = 32'(-16'sd72) & 32'hFFFF;
    v[REG_AC3] = 32'(-16'sd14383) & 32'hFFFF;
    v[REG_AC4] = 32'd32741;
    v[REG_AC56] = {16'd32757, 16'd23153};
    v[REG_B1] = 32'd6190;
    v[REG_B2] = 32'd4;
    v[REG_MCMD] = {16'hDDE9, 16'd2868}; // mc -8727
  endfunction

  function automatic void random_cal(bit near, output bit [31:0] v[8]);
    typical_cal(v);
    for (int i = 0; i < 8; i++) begin
      if (near) v[i] = v[i] ^ ($urandom & ((i == REG_AC56 || i == REG_MCMD) ?
                                           32'h01FF_01FF : 32'h01FF));
      else v[i] = $urandom;
    end
  endfunction

  task automatic test_reset_defaults();
    // all-zero calibration gives a zero temperature divisor
    send_word(16'd0, 16'd0);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'd27898, 16'd23843);
    pause(1);
  endtask

  task automatic test_directed();
    bit [31:0] v[8];
    typical_cal(v);
    load_cal(v);
    send_word(16'd27898, 16'd23843);
    send_word(16'd0, 16'd0);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'hFFFF, 16'h0000);
    send_word(16'h5555, 16'hAAAA);
    send_word(16'hAAAA, 16'h5555);
    // x1 equals ut, so ut of 100 cancels md of -100
    v[REG_AC56] = {16'h8000, 16'h0000};
    v[REG_MCMD] = {16'h8000, 16'hFF9C};
    load_cal(v);
    send_word(16'd100, 16'd23843);
    send_word(16'd99, 16'd23843);
    send_word(16'd101, 16'hFFFF);
    // zero base scale factor forces the pressure divisor to zero
    typical_cal(v);
    v[REG_AC4] = 32'd0;
    load_cal(v);
    send_word(16'd27898, 16'd23843);
    send_word(16'hFFFF, 16'd0);
    // extremes of every register
    for (int i = 0; i < 8; i++) v[i] = 32'hFFFF_FFFF;
    load_cal(v);
    send_word(16'd0, 16'hFFFF);
    send_word(16'hFFFF, 16'd0);
    send_word(16'h8000, 16'h8000);
    for (int i = 0; i < 8; i++) v[i] = 32'h7FFF_7FFF;
    v[REG_AC4] = 32'hFFFF;
    load_cal(v);
    send_word(16'd0, 16'hFFFF);
    send_word(16'hFFFF, 16'd0);
    for (int i = 0; i < 8; i++) v[i] = 32'h8000_8000;
    load_cal(v);
    send_word(16'd0, 16'd0);
    send_word(16'hFFFF, 16'hFFFF);
    pause(1);
  endtask

  task automatic test_random(int sets, int per_set);
    bit [31:0] v[8];
    bit [15:0] ut, up;
    for (int s = 0; s < sets; s++) begin
      random_cal($urandom_range(0, 2) != 0, v);
      load_cal(v);
      for (int n = 0; n < per_set; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          ut = 16'($urandom_range(20000, 36000));
          up = 16'($urandom_range(15000, 32000));
        end else begin
          ut = 16'($urandom);
          up = 16'($urandom);
        end
        send_word(ut, up);
        maybe_gap();
      end
      pause(1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random(6, 300);
    calm = 1;
    test_random(1, 200);
    drain();
    $display("sent %0d words and checked %0d results", words_in, words_out);
    $display("status ok %0d, temperature divisor zero %0d, pressure divisor zero %0d",
             stat_seen[0], stat_seen[1], stat_seen[2]);
    if (errors == 0 && pending.size() == 0) begin
      $display("baro_temp_pressure_compensation regression: pass");
    end else begin
      $display("baro_temp_pressure_compensation regression: fail");
    end
    $finish;
  end

endmodule
